>>> src/soc_pkg.sv
// ----------------------------------------------------------------------------
// soc_pkg
// Shared types and constants for the substring occurrence counter.
// ----------------------------------------------------------------------------
package soc_pkg;

    // item kinds on the input channel
    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_TEXT    = 1'b1;

    // saturation limit of the occurrence count
    localparam int unsigned COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // input item
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [COUNT_W-1:0] match_count;
        logic               pattern_too_long;
    } out_item_t;

    // per-cell control from the job sequencing logic
    typedef struct packed {
        logic scan;     // text item accepted this cycle
        logic write;    // pattern item lands in this cell
        logic clear;    // job ends this cycle
        logic active;   // cell lies inside the loaded pattern
        logic top;      // cell holds the last pattern position
    } cell_ctrl_t;

endpackage

>>> src/soc_cell.sv
// ----------------------------------------------------------------------------
// soc_cell
// One pattern position: stores its pattern byte and the partial-match bit,
// and hands the bit on to the next position.
// ----------------------------------------------------------------------------
module soc_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  soc_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]          data_byte,
    input  logic                prev_match,
    output logic                match,
    output logic                hit
);
    import soc_pkg::*;

    logic [7:0] char_reg;
    logic       match_reg;
    logic       match_next;
    logic       new_match;

    // compare against the incoming text byte, chained from the position below
    assign new_match = prev_match && (char_reg == data_byte);

    always_comb begin
        match_next = match_reg;
        if (ctrl.clear || ctrl.write) begin
            match_next = 1'b0;
        end else if (ctrl.scan && ctrl.active) begin
            match_next = new_match;
        end
    end

    // full pattern seen when the top position completes
    assign hit   = ctrl.scan && ctrl.top && new_match;
    assign match = match_reg;

    // pattern byte needs no reset
    always_ff @(posedge aclk) begin
        if (ctrl.write) begin
            char_reg <= data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

endmodule

>>> src/soc_tally.sv
// ----------------------------------------------------------------------------
// soc_tally
// Second stage: adds registered hits to the saturating total and builds the
// result item in an output register on the last text byte.
// ----------------------------------------------------------------------------
module soc_tally (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    input  logic               in_hit,
    input  logic               in_last,
    input  logic               in_ovf,
    output logic               blocked,
    output logic               m_valid,
    input  logic               m_ready,
    output soc_pkg::out_item_t m_data
);
    import soc_pkg::*;

    logic               p_valid_reg, p_valid_next;
    logic               p_hit_reg;
    logic               p_last_reg;
    logic               p_ovf_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;
    logic [COUNT_W-1:0] count_sum;

    // a finished job can only move on once the output register is free
    assign blocked = p_valid_reg && p_last_reg && m_valid_reg && !m_ready;

    assign count_sum = (p_hit_reg && (count_reg != COUNT_MAX)) ?
                       count_reg + COUNT_W'(1) : count_reg;

    always_comb begin
        p_valid_next = p_valid_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (!blocked) begin
            p_valid_next = in_fire;
            if (p_valid_reg) begin
                if (p_last_reg) begin
                    m_valid_next                 = 1'b1;
                    m_data_next.match_count      = p_ovf_reg ? '0 : count_sum;
                    m_data_next.pattern_too_long = p_ovf_reg;
                    count_next                   = '0;
                end else begin
                    count_next = count_sum;
                end
            end
        end
    end

    // payload side of the stage and the output
    always_ff @(posedge aclk) begin
        if (!blocked) begin
            p_hit_reg  <= in_hit;
            p_last_reg <= in_last;
            p_ovf_reg  <= in_ovf;
        end
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> src/substring_occurrence_counter_top.sv
// After its last text item is accepted, a result passes the tally stage register and then the output register.
// Throughput: one item per cycle while s_ready is high; the cell row compares every position at once.
// Input stalls only while a finished result waits and the next one is ready too.
// Reset (aresetn low, synchronous) clears pattern length, match bits, totals and
// both valid flags; stored pattern bytes are left as they are.
// ----------------------------------------------------------------------------
// substring_occurrence_counter_top
// Counts overlapping pattern occurrences in a text stream using a row of
// compare cells, one per pattern position, followed by a tally stage.
// ----------------------------------------------------------------------------
module substring_occurrence_counter_top #(
    parameter int PATTERN_MAX = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  soc_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output soc_pkg::out_item_t m_data
);
    import soc_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   ovf_reg, ovf_next;
    logic                   blocked;
    logic                   accept;
    logic                   pat_wr;
    logic                   txt;
    logic                   job_end;
    logic                   len_full;
    logic [PATTERN_MAX:0]   chain;
    logic [PATTERN_MAX-1:0] hits;

    assign s_ready  = !blocked;
    assign accept   = s_valid && s_ready;
    assign pat_wr   = accept && (s_data.kind == KIND_PATTERN);
    assign txt      = accept && (s_data.kind == KIND_TEXT);
    assign job_end  = txt && s_data.last;
    assign len_full = (len_reg == LEN_W'(PATTERN_MAX));

    // pattern length and overflow flag
    always_comb begin
        len_next = len_reg;
        ovf_next = ovf_reg;
        if (job_end) begin
            len_next = '0;
            ovf_next = 1'b0;
        end else if (pat_wr) begin
            if (len_full) begin
                ovf_next = 1'b1;
            end else begin
                len_next = len_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end else begin
            len_reg <= len_next;
            ovf_reg <= ovf_next;
        end
    end

    // row of compare cells; position zero always starts a match
    assign chain[0] = 1'b1;

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        cell_ctrl_t ctrl;

        assign ctrl.scan   = txt;
        assign ctrl.write  = pat_wr && (len_reg == LEN_W'(k));
        assign ctrl.clear  = job_end;
        assign ctrl.active = (LEN_W'(k) < len_reg);
        assign ctrl.top    = (len_reg == LEN_W'(k + 1));

        soc_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .data_byte  (s_data.data_byte),
            .prev_match (chain[k]),
            .match      (chain[k+1]),
            .hit        (hits[k])
        );
    end

    // tally stage and result register
    soc_tally u_tally (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (txt),
        .in_hit  (|hits),
        .in_last (s_data.last),
        .in_ovf  (ovf_reg),
        .blocked (blocked),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pattern and text items into the occurrence counter with random gaps
// on both channels, predicts each count from its own copy of the job state
// and compares every result field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
    import soc_pkg::*;

    localparam int PAT_MAX    = 64;
    localparam int RAND_ITEMS = 1600;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // predicted job state
    logic [7:0]         pattern_bytes [PAT_MAX];
    int                 pattern_len;
    logic [PAT_MAX-1:0] match_bits;
    logic [COUNT_W-1:0] occ_total;
    logic               pattern_overflow;

    out_item_t expected_counts [$];
    int        fail_count = 0;
    int        items_sent = 0;

    substring_occurrence_counter_top #(
        .PATTERN_MAX(PAT_MAX)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #10 aclk = ~aclk;

    // mostly no gap, sometimes a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    function automatic void clear_job();
        pattern_len      = 0;
        match_bits       = '0;
        occ_total        = '0;
        pattern_overflow = 1'b0;
    endfunction

    // advance the job state by one accepted item; queue a count on the last text item
    function automatic void count_occurrences(in_item_t it);
        logic [PAT_MAX-1:0] shifted;
        logic [PAT_MAX-1:0] next_bits;
        out_item_t          res;
        if (it.kind == KIND_PATTERN) begin
            if (pattern_len < PAT_MAX) begin
                pattern_bytes[pattern_len] = it.data_byte;
                match_bits[pattern_len]    = 1'b0;
                pattern_len++;
            end else begin
                pattern_overflow = 1'b1;
            end
            return;
        end
        if (pattern_len != 0) begin
            shifted = {match_bits[PAT_MAX-2:0], 1'b1};
            for (int k = 0; k < PAT_MAX; k++) begin
                if (k < pattern_len)
                    next_bits[k] = shifted[k] && (pattern_bytes[k] == it.data_byte);
                else
                    next_bits[k] = match_bits[k];
            end
            match_bits = next_bits;
            if (match_bits[pattern_len-1] && occ_total != COUNT_MAX)
                occ_total++;
        end
        if (it.last) begin
            res.match_count      = pattern_overflow ? '0 : occ_total;
            res.pattern_too_long = pattern_overflow;
            expected_counts.push_back(res);
            clear_job();
        end
    endfunction

    // one item: optional gap, then hold valid until accepted
    task automatic send_item(input in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        count_occurrences(it);
        items_sent++;
    endtask

    task automatic send_pattern(input logic [7:0] b, input logic l);
        in_item_t it;
        it.kind      = KIND_PATTERN;
        it.data_byte = b;
        it.last      = l;
        send_item(it);
    endtask

    task automatic send_text(input logic [7:0] b, input logic l);
        in_item_t it;
        it.kind      = KIND_TEXT;
        it.data_byte = b;
        it.last      = l;
        send_item(it);
    endtask

    // sender holds off until every pending count is back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_counts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // overlapping occurrences of short patterns
    task automatic test_basic_matches();
        send_pattern("a", 1'b0);
        send_pattern("b", 1'b0);
        for (int i = 0; i < 6; i++) send_text((i % 2) ? "b" : "a", i == 5);
        send_pattern("a", 1'b0);
        send_pattern("a", 1'b0);
        for (int i = 0; i < 4; i++) send_text("a", i == 3);
    endtask

    // empty pattern, short text, last on a pattern item, late pattern append
    task automatic test_edge_cases();
        send_text(8'h00, 1'b1);
        send_pattern(8'hFF, 1'b0);
        send_pattern(8'h00, 1'b0);
        send_text(8'hFF, 1'b1);
        send_pattern(8'h78, 1'b1);
        send_text(8'h78, 1'b1);
        send_pattern("a", 1'b0);
        send_text("b", 1'b0);
        send_text("a", 1'b0);
        send_pattern("b", 1'b1);
        send_text("a", 1'b0);
        send_text("b", 1'b0);
        send_text("a", 1'b0);
        send_text("b", 1'b1);
    endtask

    // full-length pattern, then one byte too many
    task automatic test_pattern_overflow();
        for (int n = PAT_MAX; n <= PAT_MAX + 1; n++) begin
            for (int i = 0; i < n; i++) send_pattern(8'(i * 4 + 3), 1'b0);
            for (int i = 0; i < PAT_MAX; i++) send_text(8'(i * 4 + 3), i == PAT_MAX - 1);
        end
    endtask

    // random jobs, mostly short patterns over a narrow alphabet
    task automatic test_random_jobs();
        logic [7:0] job_pattern [$];
        logic [7:0] syms [2];
        logic [7:0] b;
        int         plen;
        int         tlen;
        int         r;
        int         jobs;
        int         stop_at;
        bit         wide;
        bit         copy;
        jobs    = 0;
        stop_at = items_sent + RAND_ITEMS;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 5)       plen = 0;
            else if (r < 80) plen = $urandom_range(1, 4);
            else if (r < 93) plen = $urandom_range(5, PAT_MAX);
            else             plen = $urandom_range(PAT_MAX + 1, PAT_MAX + 6);
            syms[0] = 8'($urandom_range(0, 255));
            syms[1] = 8'($urandom_range(0, 255));
            wide = ($urandom_range(0, 4) == 0);
            copy = ($urandom_range(0, 3) == 0);
            job_pattern.delete();
            for (int i = 0; i < plen; i++) begin
                b = wide ? 8'($urandom_range(0, 255)) : syms[$urandom_range(0, 1)];
                job_pattern.push_back(b);
                send_pattern(b, 1'($urandom_range(0, 1)));
            end
            tlen = (plen > 4) ? plen + $urandom_range(0, 24) : $urandom_range(1, 40);
            for (int i = 0; i < tlen; i++) begin
                // occasional pattern item in the middle of the text
                if ($urandom_range(0, 29) == 0) begin
                    b = syms[$urandom_range(0, 1)];
                    job_pattern.push_back(b);
                    send_pattern(b, 1'($urandom_range(0, 1)));
                end
                if (copy && job_pattern.size() > 0 && $urandom_range(0, 7) != 0)
                    b = job_pattern[i % job_pattern.size()];
                else if (wide)
                    b = 8'($urandom_range(0, 255));
                else
                    b = syms[$urandom_range(0, 1)];
                send_text(b, i == tlen - 1);
            end
            jobs++;
            if (jobs % 40 == 0) wait_for_results();
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        out_item_t exp_item;
        if (aresetn && m_valid && m_ready) begin
            if (expected_counts.size() == 0) begin
                $error("unexpected result: match_count %0d pattern_too_long %0b",
                       m_data.match_count, m_data.pattern_too_long);
                fail_count++;
            end else begin
                exp_item = expected_counts.pop_front();
                if (m_data.match_count !== exp_item.match_count) begin
                    $error("match_count: expected %0d, got %0d",
                           exp_item.match_count, m_data.match_count);
                    fail_count++;
                end
                if (m_data.pattern_too_long !== exp_item.pattern_too_long) begin
                    $error("pattern_too_long: expected %0b, got %0b",
                           exp_item.pattern_too_long, m_data.pattern_too_long);
                    fail_count++;
                end
            end
        end
    end

    // receiver: ready runs broken by random stalls
    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            g = pick_gap();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
        end
    end

    // run limit
    initial begin
        #20ms;
        $display("substring_occurrence_counter_top test failed");
        $finish;
    end

    // main sequence
    initial begin
        for (int i = 0; i < PAT_MAX; i++) pattern_bytes[i] = '0;
        clear_job();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_matches();
        test_edge_cases();
        test_pattern_overflow();
        test_random_jobs();
        wait_for_results();
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("substring_occurrence_counter_top test passed");
        else
            $display("substring_occurrence_counter_top test failed");
        $finish;
    end

endmodule
